// ----- rtl/pcfd_pkg.sv -----
// pcfd_pkg: constants, types and the fan curve table for the power curve fan duty block
// self-contained; used by power_curve_fan_duty_top through scoped names
package pcfd_pkg;

    localparam int RATIO_FRAC_BITS    = 8;
    localparam int TEMP_WIDTH_DEFAULT = 16;
    localparam int DUTY_W             = 8;
    localparam int DUTY_MAX           = 255;
    localparam int MIN_DUTY_RESET     = 75;
    localparam int FAIL_TEMP_RESET    = -1280;

    // curve exponent 1.6 = 8/5
    localparam int EXP_NUM = 8;
    localparam int EXP_DEN = 5;

    localparam int SCALE       = 1 << RATIO_FRAC_BITS;
    localparam int Q_W         = RATIO_FRAC_BITS + 1;
    // full scale maps to DUTY_MAX and stays out of the table
    localparam int CURVE_DEPTH = SCALE;
    localparam int CNT_W       = $clog2(RATIO_FRAC_BITS);
    localparam int BIG_W       = 8 * EXP_DEN + EXP_NUM * Q_W + 8;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_DUTY  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FAIL_TEMP = 1'b1;

    typedef logic [DUTY_W-1:0] duty_t;
    typedef duty_t [CURVE_DEPTH-1:0] curve_rom_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_LOOK = 4'b1000
    } state_t;

    // largest y in 0..255 with y^5 * S^8 <= 255^5 * q^8
    function automatic duty_t curve_point(input int unsigned q);
        logic [BIG_W-1:0] rhs;
        logic [BIG_W-1:0] lhs;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        rhs = BIG_W'(1);
        for (int k = 0; k < EXP_DEN; k++) begin
            rhs = rhs * BIG_W'(DUTY_MAX);
        end
        for (int k = 0; k < EXP_NUM; k++) begin
            rhs = rhs * BIG_W'(q);
        end
        lo = 0;
        hi = DUTY_MAX;
        for (int i = 0; i < DUTY_W; i++) begin
            if (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                lhs = BIG_W'(1);
                for (int k = 0; k < EXP_DEN; k++) begin
                    lhs = lhs * BIG_W'(mid);
                end
                lhs = lhs << (EXP_NUM * RATIO_FRAC_BITS);
                if (lhs <= rhs) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
        end
        return DUTY_W'(lo);
    endfunction

    function automatic curve_rom_t build_curve_rom();
        curve_rom_t rom;
        for (int q = 0; q < CURVE_DEPTH; q++) begin
            rom[q] = curve_point(q);
        end
        return rom;
    endfunction

    localparam curve_rom_t CURVE_ROM = build_curve_rom();

endpackage

// ----- rtl/power_curve_fan_duty_top.sv -----
// power_curve_fan_duty_top: fan duty from the hottest sensor of a control period
// depends on pcfd_pkg (curve table, state codes, register indexes)
// steps in range: idle, prepare, 8 quotient bits, lookup; a clamped position
// skips the divider; the bit-serial divider gives one quotient bit a cycle
// last sensor: lookup loads the result, waiting while output held; input taken only in idle
// reset: aresetn synchronous active low; registers to defaults, running max and last duty to 0
module power_curve_fan_duty_top #(
    parameter int TEMP_WIDTH = pcfd_pkg::TEMP_WIDTH_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [TEMP_WIDTH-1:0]          s_temperature,
    input  logic signed [TEMP_WIDTH-1:0]          s_crit_high,
    input  logic signed [TEMP_WIDTH-1:0]          s_crit_low,
    input  logic                                  s_read_failed,
    input  logic                                  s_last_sensor,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [pcfd_pkg::DUTY_W-1:0]           m_duty,
    output logic                                  m_changed,
    input  logic                                  cfg_we,
    input  logic [pcfd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [TEMP_WIDTH-1:0]                 cfg_wdata
);

    localparam int DW   = pcfd_pkg::DUTY_W;
    localparam int QW   = pcfd_pkg::Q_W;
    localparam int CW   = pcfd_pkg::CNT_W;

    pcfd_pkg::state_t state_reg, state_next;

    logic [DW-1:0]                 min_duty_reg, min_duty_next;
    logic [TEMP_WIDTH-1:0]         fail_temp_reg, fail_temp_next;
    logic [DW-1:0]                 running_max_reg, running_max_next;
    logic [DW-1:0]                 previous_duty_reg, previous_duty_next;

    logic [TEMP_WIDTH-1:0]         t_reg, t_next;
    logic [TEMP_WIDTH-1:0]         high_reg, high_next;
    logic [TEMP_WIDTH-1:0]         low_reg, low_next;
    logic                          last_reg, last_next;
    logic [TEMP_WIDTH-1:0]         rem_reg, rem_next;
    logic [TEMP_WIDTH-1:0]         den_reg, den_next;
    logic [QW-1:0]                 q_reg, q_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;

    logic                          m_valid_reg, m_valid_next;
    logic [DW-1:0]                 m_duty_reg, m_duty_next;
    logic                          m_changed_reg, m_changed_next;

    logic signed [TEMP_WIDTH:0]    num;
    logic signed [TEMP_WIDTH:0]    den;
    logic [TEMP_WIDTH:0]           rem_shift;
    logic [TEMP_WIDTH:0]           rem_sub;
    logic                          quo_bit;
    logic [DW-1:0]                 curve_val;
    logic [DW-1:0]                 max_val;
    logic [DW-1:0]                 duty;
    logic                          out_free;
    logic                          load;

    assign num       = {t_reg[TEMP_WIDTH-1], t_reg} - {low_reg[TEMP_WIDTH-1], low_reg};
    assign den       = {high_reg[TEMP_WIDTH-1], high_reg} - {low_reg[TEMP_WIDTH-1], low_reg};
    assign rem_shift = {rem_reg, 1'b0};
    assign quo_bit   = rem_shift >= {1'b0, den_reg};
    assign rem_sub   = rem_shift - {1'b0, den_reg};
    assign curve_val = q_reg[QW-1] ? DW'(pcfd_pkg::DUTY_MAX)
                                   : pcfd_pkg::CURVE_ROM[q_reg[QW-2:0]];
    assign max_val   = (curve_val > running_max_reg) ? curve_val : running_max_reg;
    assign duty      = (max_val < min_duty_reg) ? min_duty_reg : max_val;
    assign out_free  = !m_valid_reg || m_ready;

    assign s_ready   = (state_reg == pcfd_pkg::ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_duty    = m_duty_reg;
    assign m_changed = m_changed_reg;

    always_comb begin
        state_next         = state_reg;
        min_duty_next      = min_duty_reg;
        fail_temp_next     = fail_temp_reg;
        running_max_next   = running_max_reg;
        previous_duty_next = previous_duty_reg;
        t_next             = t_reg;
        high_next          = high_reg;
        low_next           = low_reg;
        last_next          = last_reg;
        rem_next           = rem_reg;
        den_next           = den_reg;
        q_next             = q_reg;
        cnt_next           = cnt_reg;
        m_duty_next        = m_duty_reg;
        m_changed_next     = m_changed_reg;
        load               = 1'b0;

        if (cfg_we) begin
            case (cfg_index)
                pcfd_pkg::REG_MIN_DUTY:  min_duty_next  = cfg_wdata[DW-1:0];
                pcfd_pkg::REG_FAIL_TEMP: fail_temp_next = cfg_wdata;
                default: ;
            endcase
        end

        case (state_reg)
            pcfd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    t_next     = s_read_failed ? fail_temp_reg : s_temperature;
                    high_next  = s_crit_high;
                    low_next   = s_crit_low;
                    last_next  = s_last_sensor;
                    state_next = pcfd_pkg::ST_PREP;
                end
            end
            pcfd_pkg::ST_PREP: begin
                if (den[TEMP_WIDTH] || den == '0 || num[TEMP_WIDTH] || num == '0) begin
                    q_next     = '0;
                    state_next = pcfd_pkg::ST_LOOK;
                end else if (num >= den) begin
                    q_next     = QW'(pcfd_pkg::SCALE);
                    state_next = pcfd_pkg::ST_LOOK;
                end else begin
                    rem_next   = num[TEMP_WIDTH-1:0];
                    den_next   = den[TEMP_WIDTH-1:0];
                    q_next     = '0;
                    cnt_next   = '0;
                    state_next = pcfd_pkg::ST_DIV;
                end
            end
            pcfd_pkg::ST_DIV: begin
                rem_next = quo_bit ? rem_sub[TEMP_WIDTH-1:0] : rem_shift[TEMP_WIDTH-1:0];
                q_next   = {q_reg[QW-2:0], quo_bit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(pcfd_pkg::RATIO_FRAC_BITS - 1)) begin
                    state_next = pcfd_pkg::ST_LOOK;
                end
            end
            pcfd_pkg::ST_LOOK: begin
                if (!last_reg) begin
                    running_max_next = max_val;
                    state_next       = pcfd_pkg::ST_IDLE;
                end else if (out_free) begin
                    load               = 1'b1;
                    m_duty_next        = duty;
                    m_changed_next     = (duty != previous_duty_reg);
                    previous_duty_next = duty;
                    running_max_next   = '0;
                    state_next         = pcfd_pkg::ST_IDLE;
                end
            end
            default: state_next = pcfd_pkg::ST_IDLE;
        endcase

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= pcfd_pkg::ST_IDLE;
            min_duty_reg      <= DW'(pcfd_pkg::MIN_DUTY_RESET);
            fail_temp_reg     <= TEMP_WIDTH'(pcfd_pkg::FAIL_TEMP_RESET);
            running_max_reg   <= '0;
            previous_duty_reg <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            min_duty_reg      <= min_duty_next;
            fail_temp_reg     <= fail_temp_next;
            running_max_reg   <= running_max_next;
            previous_duty_reg <= previous_duty_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        t_reg         <= t_next;
        high_reg      <= high_next;
        low_reg       <= low_next;
        last_reg      <= last_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        q_reg         <= q_next;
        cnt_reg       <= cnt_next;
        m_duty_reg    <= m_duty_next;
        m_changed_reg <= m_changed_next;
    end

`ifndef SYNTHESIS
    a_div_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pcfd_pkg::ST_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_position_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pcfd_pkg::ST_LOOK) |-> (q_reg <= QW'(pcfd_pkg::SCALE)))
        else $error("position above full scale");

    a_duty_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_duty_reg >= min_duty_reg))
        else $error("duty below minimum");

    a_period_close: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (running_max_reg == '0 && m_valid_reg
                  && previous_duty_reg == m_duty_reg))
        else $error("period close did not clear running max or track duty");
`endif

endmodule
